/* rtl/core/scvf_pkg.sv */
// Shared constants for the sphere cell volume fraction block.
// Used by the modules under rtl/core except scvf_queue; depends on nothing.
package scvf_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int MAX_SUBDIV_DEF = 16;

	localparam int SUBDIV_W = 5;
	localparam int CLASS_W  = 2;
	localparam int COUNT_W  = 13;
	localparam int TOTAL_W  = 24;
	localparam int INDEX_W  = 3;
	localparam int M_DATA_W = 40;

	localparam logic [CLASS_W-1:0] CLASS_OUT  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FULL = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_PART = 2'd2;

	localparam logic [INDEX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [INDEX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [INDEX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [INDEX_W-1:0] REG_RADIUS   = 3'd3;
	localparam logic [INDEX_W-1:0] REG_SUBDIV   = 3'd4;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

endpackage

/* rtl/core/scvf_queue.sv */
// Short job queue between the classifying front and the counting back.
// Plain flip-flop storage; depends on nothing.
module scvf_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end
endmodule

/* rtl/core/scvf_front.sv */
// Front part: accepts cells and classifies them by their eight corners.
// Depends on scvf_pkg.
module scvf_front #(
	parameter int COORD_BITS = scvf_pkg::COORD_BITS_DEF,
	parameter int IN_W       = 144,
	parameter int JOB_W      = 2 + 6 * COORD_BITS - 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,
	input  logic [COORD_BITS-1:0] cx,
	input  logic [COORD_BITS-1:0] cy,
	input  logic [COORD_BITS-1:0] cz,
	input  logic [COORD_BITS-2:0] radius,
	output logic                  job_push,
	output logic [JOB_W-1:0]      job_data,
	input  logic                  job_full
);
	localparam int CB   = COORD_BITS;
	localparam int DW   = CB + 2;
	localparam int SQW  = 2 * DW;
	localparam int SUMW = SQW + 2;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CORN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	logic [1:0]          state_q;
	logic [2:0]          corner_q;
	logic [CB-1:0]       xl_q, yl_q, zl_q;
	logic [CB-2:0]       dx_q, dy_q, dz_q;
	logic                all_in_q, any_on_q;
	logic                v_s1;
	logic signed [SQW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [SUMW-1:0]     r2_q;
	logic [2*CB-3:0]     rr;
	logic signed [DW-1:0] px, py, pz;
	logic signed [SQW-1:0] sqx, sqy, sqz;
	logic [SUMW-1:0]     dist2;
	logic [1:0]          cls;

	assign rr = radius * radius;

	always_comb begin
		px = $signed({{2{xl_q[CB-1]}}, xl_q}) - $signed({{2{cx[CB-1]}}, cx})
			+ (corner_q[0] ? $signed({3'b000, dx_q}) : DW'(0));
		py = $signed({{2{yl_q[CB-1]}}, yl_q}) - $signed({{2{cy[CB-1]}}, cy})
			+ (corner_q[1] ? $signed({3'b000, dy_q}) : DW'(0));
		pz = $signed({{2{zl_q[CB-1]}}, zl_q}) - $signed({{2{cz[CB-1]}}, cz})
			+ (corner_q[2] ? $signed({3'b000, dz_q}) : DW'(0));
		sqx = px * px;
		sqy = py * py;
		sqz = pz * pz;
		dist2 = SUMW'($unsigned(sqx_s1)) + SUMW'($unsigned(sqy_s1))
			+ SUMW'($unsigned(sqz_s1));
		if (all_in_q)
			cls = scvf_pkg::CLASS_FULL;
		else if (any_on_q)
			cls = scvf_pkg::CLASS_PART;
		else
			cls = scvf_pkg::CLASS_OUT;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign job_push = (state_q == ST_PUSH) && !job_full;
	assign job_data = {dz_q, dy_q, dx_q, zl_q, yl_q, xl_q, cls};

	always_ff @(posedge clk) begin
		sqx_s1 <= sqx;
		sqy_s1 <= sqy;
		sqz_s1 <= sqz;
		r2_q   <= SUMW'(rr);
		if (s_tvalid && s_tready) begin
			xl_q <= s_tdata[0 +: CB];
			yl_q <= s_tdata[CB +: CB];
			zl_q <= s_tdata[2*CB +: CB];
			dx_q <= s_tdata[3*CB +: CB-1];
			dy_q <= s_tdata[4*CB-1 +: CB-1];
			dz_q <= s_tdata[5*CB-2 +: CB-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= '0;
			v_s1     <= 1'b0;
			all_in_q <= 1'b1;
			any_on_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_CORN);
			if (v_s1) begin
				if (dist2 >= r2_q)
					all_in_q <= 1'b0;
				if (dist2 <= r2_q)
					any_on_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						corner_q <= '0;
						all_in_q <= 1'b1;
						any_on_q <= 1'b0;
						state_q  <= ST_CORN;
					end
				end
				ST_CORN: begin
					corner_q <= corner_q + 1'b1;
					if (corner_q == 3'd7)
						state_q <= ST_LAST;
				end
				ST_LAST: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (!job_full)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/scvf_back.sv */
// Back part: counts sub-cell centres of partial cells, keeps the partial
// cell total and holds the output register. Depends on scvf_pkg.
module scvf_back #(
	parameter int COORD_BITS = scvf_pkg::COORD_BITS_DEF,
	parameter int MAX_SUBDIV = scvf_pkg::MAX_SUBDIV_DEF,
	parameter int JOB_W      = 2 + 6 * COORD_BITS - 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_empty,
	input  logic [JOB_W-1:0]              job_data,
	output logic                          job_pop,
	input  logic [COORD_BITS-1:0]         cx,
	input  logic [COORD_BITS-1:0]         cy,
	input  logic [COORD_BITS-1:0]         cz,
	input  logic [COORD_BITS-2:0]         radius,
	input  logic [scvf_pkg::SUBDIV_W-1:0] subdiv,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [scvf_pkg::M_DATA_W-1:0] m_tdata
);
	localparam int CB   = COORD_BITS;
	localparam int IW   = $clog2(MAX_SUBDIV + 1);
	localparam int SW   = IW + 1;
	localparam int PW   = CB + SW + 2;
	localparam int SQW  = 2 * PW;
	localparam int SUMW = SQW + 2;
	localparam int MRW  = SW + CB - 1;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_SETUP = 3'd1;
	localparam logic [2:0] B_INIT  = 3'd2;
	localparam logic [2:0] B_RUN   = 3'd3;
	localparam logic [2:0] B_DRAIN = 3'd4;
	localparam logic [2:0] B_OUT   = 3'd5;

	logic [2:0]            state_q;
	logic [1:0]            cls_q;
	logic [CB-1:0]         xl_q, yl_q, zl_q;
	logic [CB-2:0]         dx_q, dy_q, dz_q;
	logic [IW-1:0]         m_c, m_q, i_q, j_q, k_q;
	logic [SW-1:0]         m2_cfg, m2_q;
	logic [MRW-1:0]        mr_q;
	logic [2*MRW-1:0]      mr_sq;
	logic [SUMW-1:0]       rs_q;
	logic signed [PW-1:0]  bx_q, by_q, bz_q, sx_q, sy_q, sz_q, y0_q, z0_q;
	logic signed [CB:0]    dcx, dcy, dcz;
	logic signed [SQW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic                  v_s1;
	logic [SUMW-1:0]       dist2;
	logic [scvf_pkg::COUNT_W-1:0] cnt_q, ocnt_q;
	logic [scvf_pkg::TOTAL_W-1:0] total_q, total_nx;
	logic [1:0]            ocls_q;
	logic                  ovld_q;
	logic                  last_pt, k_end, j_end, load_out;

	always_comb begin
		if (subdiv == '0)
			m_c = IW'(1);
		else if (32'(subdiv) > MAX_SUBDIV)
			m_c = IW'(MAX_SUBDIV);
		else
			m_c = IW'(subdiv);
		m2_cfg = {m_c, 1'b0};
		m2_q   = {m_q, 1'b0};
		mr_sq  = mr_q * mr_q;
		dcx = $signed({xl_q[CB-1], xl_q}) - $signed({cx[CB-1], cx});
		dcy = $signed({yl_q[CB-1], yl_q}) - $signed({cy[CB-1], cy});
		dcz = $signed({zl_q[CB-1], zl_q}) - $signed({cz[CB-1], cz});
		dist2 = SUMW'($unsigned(sqx_s1)) + SUMW'($unsigned(sqy_s1))
			+ SUMW'($unsigned(sqz_s1));
		k_end   = (k_q == m_q - 1'b1);
		j_end   = (j_q == m_q - 1'b1);
		last_pt = k_end && j_end && (i_q == m_q - 1'b1);
		total_nx = (total_q != scvf_pkg::TOTAL_MAX) ? total_q + 1'b1 : total_q;
	end

	assign load_out = (state_q == B_OUT) && (!ovld_q || m_tready);
	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign m_tvalid = ovld_q;
	assign m_tdata  = {1'b0, total_q, ocnt_q, ocls_q};

	always_ff @(posedge clk) begin
		mr_q   <= m2_cfg * radius;
		rs_q   <= SUMW'(mr_sq);
		sqx_s1 <= sx_q * sx_q;
		sqy_s1 <= sy_q * sy_q;
		sqz_s1 <= sz_q * sz_q;
		if (job_pop) begin
			cls_q <= job_data[1:0];
			xl_q  <= job_data[2 +: CB];
			yl_q  <= job_data[2+CB +: CB];
			zl_q  <= job_data[2+2*CB +: CB];
			dx_q  <= job_data[2+3*CB +: CB-1];
			dy_q  <= job_data[1+4*CB +: CB-1];
			dz_q  <= job_data[5*CB +: CB-1];
			m_q   <= m_c;
		end
		if (state_q == B_SETUP) begin
			// Both factors are widened first so the product keeps all its bits.
			bx_q <= $signed({{(PW-SW){1'b0}}, m2_q}) * PW'(dcx);
			by_q <= $signed({{(PW-SW){1'b0}}, m2_q}) * PW'(dcy);
			bz_q <= $signed({{(PW-SW){1'b0}}, m2_q}) * PW'(dcz);
		end
		if (load_out) begin
			ocls_q <= cls_q;
			ocnt_q <= (cls_q == scvf_pkg::CLASS_PART) ? cnt_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			v_s1    <= 1'b0;
			ovld_q  <= 1'b0;
			total_q <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sz_q    <= '0;
			y0_q    <= '0;
			z0_q    <= '0;
		end else begin
			v_s1 <= (state_q == B_RUN);
			if (v_s1 && (dist2 < rs_q))
				cnt_q <= cnt_q + 1'b1;
			if (load_out)
				ovld_q <= 1'b1;
			else if (m_tready)
				ovld_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!job_empty)
						state_q <= (job_data[1:0] == scvf_pkg::CLASS_PART) ? B_SETUP : B_OUT;
				end
				B_SETUP: state_q <= B_INIT;
				B_INIT: begin
					sx_q  <= bx_q + $signed(PW'(dx_q));
					sy_q  <= by_q + $signed(PW'(dy_q));
					sz_q  <= bz_q + $signed(PW'(dz_q));
					y0_q  <= by_q + $signed(PW'(dy_q));
					z0_q  <= bz_q + $signed(PW'(dz_q));
					i_q   <= '0;
					j_q   <= '0;
					k_q   <= '0;
					cnt_q <= '0;
					state_q <= B_RUN;
				end
				B_RUN: begin
					// Innermost axis is z, then y, then x.
					if (k_end) begin
						k_q  <= '0;
						sz_q <= z0_q;
						if (j_end) begin
							j_q  <= '0;
							sy_q <= y0_q;
							i_q  <= i_q + 1'b1;
							sx_q <= sx_q + $signed(PW'({dx_q, 1'b0}));
						end else begin
							j_q  <= j_q + 1'b1;
							sy_q <= sy_q + $signed(PW'({dy_q, 1'b0}));
						end
					end else begin
						k_q  <= k_q + 1'b1;
						sz_q <= sz_q + $signed(PW'({dz_q, 1'b0}));
					end
					if (last_pt)
						state_q <= B_DRAIN;
				end
				B_DRAIN: state_q <= B_OUT;
				B_OUT: begin
					if (load_out) begin
						if (cls_q == scvf_pkg::CLASS_PART)
							total_q <= total_nx;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/sphere_cell_volume_fraction.sv */
// Top level of the sphere cell volume fraction block: configuration
// registers, front classifier, job queue and back counter.
// Depends on scvf_pkg, scvf_front, scvf_queue and scvf_back.
//
//   channel  direction  signals                       payload
//   s        in         s_tvalid s_tready s_tdata     cell corner and widths
//   m        out        m_tvalid m_tready m_tdata     class, count, total
//   cfg      in         cfg_we cfg_index cfg_data     register writes
//
// The front works on one cell at a time, squaring its eight corners in turn
// and then finishing the compare and the hand-over. A partial cell is then
// counted in the back one sub-cell centre per cycle through the squaring
// stage. Reset clears control state and loads the register defaults. The
// two-entry queue and the output register let either side stall alone.
module sphere_cell_volume_fraction #(
	parameter int MAX_SUBDIV = scvf_pkg::MAX_SUBDIV_DEF,
	parameter int COORD_BITS = scvf_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cell_x_low, cell_y_low, cell_z_low, cell_dx, cell_dy, cell_dz, zero fill
	input  logic [((6*COORD_BITS-3+7)/8)*8-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// cell_class, inside_count, partial_total, zero fill
	output logic [scvf_pkg::M_DATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [scvf_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data
);
	localparam int CB    = COORD_BITS;
	localparam int IN_W  = ((6 * CB - 3 + 7) / 8) * 8;
	localparam int JOB_W = 2 + 6 * CB - 3;

	logic [CB-1:0]                 cx_q, cy_q, cz_q;
	logic [CB-2:0]                 radius_q;
	logic [scvf_pkg::SUBDIV_W-1:0] subdiv_q;
	logic                          push, full, pop, empty;
	logic [JOB_W-1:0]              push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			radius_q <= (CB-1)'(65536);
			subdiv_q <= scvf_pkg::SUBDIV_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				scvf_pkg::REG_CENTER_X: cx_q     <= cfg_data;
				scvf_pkg::REG_CENTER_Y: cy_q     <= cfg_data;
				scvf_pkg::REG_CENTER_Z: cz_q     <= cfg_data;
				scvf_pkg::REG_RADIUS:   radius_q <= cfg_data[CB-2:0];
				scvf_pkg::REG_SUBDIV:   subdiv_q <= cfg_data[scvf_pkg::SUBDIV_W-1:0];
				default: ;
			endcase
		end
	end

	scvf_front #(.COORD_BITS(CB), .IN_W(IN_W), .JOB_W(JOB_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.cx(cx_q), .cy(cy_q), .cz(cz_q), .radius(radius_q),
		.job_push(push), .job_data(push_data), .job_full(full)
	);

	scvf_queue #(.W(JOB_W), .DEPTH(2)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	scvf_back #(.COORD_BITS(CB), .MAX_SUBDIV(MAX_SUBDIV), .JOB_W(JOB_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_empty(empty), .job_data(pop_data), .job_pop(pop),
		.cx(cx_q), .cy(cy_q), .cz(cz_q), .radius(radius_q), .subdiv(subdiv_q),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

`ifndef SYNTHESIS
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready) else $error("front took two cells in a row");
	a_class_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("illegal cell class");
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != scvf_pkg::CLASS_PART |-> m_tdata[14:2] == '0)
		else $error("count set on a cell that is not partial");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into a full queue");
`endif
endmodule

/* sim/tb_sphere_cell_volume_fraction.sv */
// Self-checking testbench for sphere_cell_volume_fraction: random cells around
// several sphere settings, with a scoreboard that predicts class and counts.
// Depends on scvf_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_sphere_cell_volume_fraction;
	import scvf_pkg::*;

	localparam int S_DATA_W   = 144;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic signed [23:0] x, y, z;
		logic [22:0]        dx, dy, dz;
	} cell_t;

	typedef struct {
		logic [CLASS_W-1:0] cls;
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] total;
	} frac_t;

	class frac_scoreboard;
		longint      cen_x, cen_y, cen_z, radius, subdiv_reg;
		logic [23:0] partials;
		frac_t       pending_fracs[$];
		int          errors;

		function new();
			cen_x = 0; cen_y = 0; cen_z = 0;
			radius = 65536; subdiv_reg = 4;
			partials = 0; errors = 0;
		endfunction

		function void set_reg(logic [INDEX_W-1:0] idx, logic [23:0] val);
			case (idx)
				REG_CENTER_X: cen_x = longint'($signed(val));
				REG_CENTER_Y: cen_y = longint'($signed(val));
				REG_CENTER_Z: cen_z = longint'($signed(val));
				REG_RADIUS:   radius = longint'(val[22:0]);
				REG_SUBDIV:   subdiv_reg = longint'(val[4:0]);
				default: ;
			endcase
		endfunction

		function logic [127:0] sq(longint s);
			logic [127:0] a;
			a = (s < 0) ? -s : s;
			return a * a;
		endfunction

		function void note_cell(cell_t c);
			longint xl, yl, zl, dx, dy, dz, m, m2, px, py, pz, sx, sy, sz;
			logic [127:0] r2, rs, d2;
			bit all_in, any_on;
			int cnt;
			frac_t f;
			xl = longint'(c.x); yl = longint'(c.y); zl = longint'(c.z);
			dx = longint'(c.dx); dy = longint'(c.dy); dz = longint'(c.dz);
			r2 = sq(radius);
			all_in = 1; any_on = 0; cnt = 0;
			for (int k = 0; k < 8; k++) begin
				px = xl + (k[0] ? dx : 0) - cen_x;
				py = yl + (k[1] ? dy : 0) - cen_y;
				pz = zl + (k[2] ? dz : 0) - cen_z;
				d2 = sq(px) + sq(py) + sq(pz);
				if (d2 >= r2) all_in = 0;
				if (d2 <= r2) any_on = 1;
			end
			f.cls = CLASS_OUT;
			if (all_in) begin
				f.cls = CLASS_FULL;
			end else if (any_on) begin
				// Subdivision is clamped into 1..MAX_SUBDIV; centres are scaled by 2*m.
				m = subdiv_reg;
				if (m < 1) m = 1;
				if (m > MAX_SUBDIV_DEF) m = MAX_SUBDIV_DEF;
				m2 = 2 * m;
				rs = sq(m2 * radius);
				for (int i = 0; i < m; i++) begin
					sx = m2 * (xl - cen_x) + (2 * i + 1) * dx;
					for (int j = 0; j < m; j++) begin
						sy = m2 * (yl - cen_y) + (2 * j + 1) * dy;
						for (int k = 0; k < m; k++) begin
							sz = m2 * (zl - cen_z) + (2 * k + 1) * dz;
							if (sq(sx) + sq(sy) + sq(sz) < rs) cnt++;
						end
					end
				end
				f.cls = CLASS_PART;
				if (partials != TOTAL_MAX) partials++;
			end
			f.count = cnt[COUNT_W-1:0];
			f.total = partials;
			pending_fracs.push_back(f);
		endfunction

		function void check_frac(logic [M_DATA_W-1:0] d);
			frac_t e;
			if (pending_fracs.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = pending_fracs.pop_front();
			if (d[1:0] !== e.cls) begin
				$display("%0t: cell_class expected %0d actual %0d", $time, e.cls, d[1:0]);
				errors++;
			end
			if (d[14:2] !== e.count) begin
				$display("%0t: inside_count expected %0d actual %0d", $time, e.count, d[14:2]);
				errors++;
			end
			if (d[38:15] !== e.total) begin
				$display("%0t: partial_total expected %0d actual %0d", $time, e.total,
					d[38:15]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 s_tvalid = 0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_we = 0;
	logic [INDEX_W-1:0]   cfg_index = REG_CENTER_X;
	logic [23:0]          cfg_data = '0;

	frac_scoreboard fracs = new();
	int             cells_sent = 0;
	longint         cycles = 0;

	sphere_cell_volume_fraction i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) fracs.check_frac(m_tdata);
	end

	// Output back-pressure; once, a long hold-off lets the block fill up.
	initial begin
		bit held;
		int r;
		held = 0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && cells_sent > 100) begin
				held = 1;
				m_tready <= 0;
				repeat (3000) @(posedge clk);
			end else if (r < 75) begin
				m_tready <= 1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_tready <= 0;
				repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 80))
					@(posedge clk);
			end
		end
	end

	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [23:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		fracs.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_sphere(int cx, int cy, int cz, int r, int sd);
		write_reg(REG_CENTER_X, cx[23:0]);
		write_reg(REG_CENTER_Y, cy[23:0]);
		write_reg(REG_CENTER_Z, cz[23:0]);
		write_reg(REG_RADIUS, r[23:0]);
		write_reg(REG_SUBDIV, sd[23:0]);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_cell(cell_t c);
		int r;
		r = $urandom_range(0, 99);
		if (r >= 60) begin
			s_tvalid <= 0;
			repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60))
				@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {3'b000, c.dz, c.dy, c.dx, c.z, c.y, c.x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		fracs.note_cell(c);
		cells_sent++;
	endtask

	function automatic cell_t make_cell(longint x, longint y, longint z,
			longint dx, longint dy, longint dz);
		cell_t c;
		c.x = x[23:0]; c.y = y[23:0]; c.z = z[23:0];
		c.dx = dx[22:0]; c.dy = dy[22:0]; c.dz = dz[22:0];
		return c;
	endfunction

	// Mostly cells straddling the surface, some anywhere, some tiny ones.
	function automatic longint near_coord(longint cen, longint span);
		return cen + longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic longint rand_width(longint hi);
		if ($urandom_range(0, 49) == 0) return 0;
		return longint'($urandom_range(1, hi));
	endfunction

	function automatic cell_t rand_cell();
		longint span, wmax;
		int mode;
		mode = $urandom_range(0, 99);
		span = fracs.radius + fracs.radius / 2 + 2;
		if (span > 12000000) span = 12000000;
		wmax = fracs.radius / 2 + 2;
		if (wmax > 8388607) wmax = 8388607;
		if (mode < 65)
			return make_cell(near_coord(fracs.cen_x, span), near_coord(fracs.cen_y, span),
				near_coord(fracs.cen_z, span), rand_width(wmax), rand_width(wmax),
				rand_width(wmax));
		else if (mode < 85)
			return make_cell($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			return make_cell(near_coord(fracs.cen_x, 4), near_coord(fracs.cen_y, 4),
				near_coord(fracs.cen_z, 4), rand_width(4), rand_width(4), rand_width(4));
	endfunction

	task automatic run_cells(int n);
		for (int i = 0; i < n; i++) send_cell(rand_cell());
		s_tvalid <= 0;
		@(posedge clk);
		while (fracs.pending_fracs.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Default sphere: unit radius at the origin, four sub-cells per axis.
		send_cell(make_cell(-16384, -16384, -16384, 32768, 32768, 32768));
		send_cell(make_cell(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
		send_cell(make_cell(-8388608, -8388608, -8388608, 1, 1, 1));
		send_cell(make_cell(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
		send_cell(make_cell(0, 0, 0, 65536, 65536, 65536));
		send_cell(make_cell(-131072, -131072, -131072, 262144, 262144, 262144));
		send_cell(make_cell(-16384, -16384, -16384, 0, 32768, 32768));
		send_cell(make_cell(-16384, -16384, -16384, 0, 0, 0));
		send_cell(make_cell(65536, 0, 0, 65536, 65536, 65536));
		send_cell(make_cell(-65536, -65536, -65536, 65536, 65536, 65536));
		run_cells(140);

		set_sphere(98304, -147456, 32768, 131072, 0);
		run_cells(200);

		// Zero radius: only a corner sitting exactly on the centre makes a cell partial.
		set_sphere(-8388608, 8388607, 0, 0, 1);
		send_cell(make_cell(-8388608, 8388607, 0, 1, 1, 1));
		send_cell(make_cell(-8388609, 8388606, -1, 1, 1, 1));
		run_cells(150);

		set_sphere(8388607, -8388608, 0, 8388607, 31);
		run_cells(25);

		set_sphere(0, 0, 0, 32768, 3);
		run_cells(300);

		set_sphere($urandom, $urandom, $urandom, 16, 2);
		run_cells(250);

		set_sphere(-4096, 12288, 65536, 262144, 5);
		run_cells(175);

		repeat (100) @(posedge clk);
		if (fracs.errors == 0 && fracs.pending_fracs.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
